>>> rtl/core/cwdf_pkg.sv
package cwdf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TURN_UNITS   = 5760;
  localparam int CNT_W        = $clog2(CORDIC_STEPS + 1);

  // register byte addresses
  localparam logic [3:0] ADDR_VANE_OFFSET  = 4'd0;
  localparam logic [3:0] ADDR_FILTER_GAIN  = 4'd4;
  localparam logic [3:0] ADDR_MANUAL_MODE  = 4'd8;
  localparam logic [3:0] ADDR_MANUAL_DIR   = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MODR,
    ST_DIV,
    ST_PREP,
    ST_ROT,
    ST_ROUND,
    ST_SMC,
    ST_SMS,
    ST_SMU,
    ST_VINIT,
    ST_VEC,
    ST_CONV,
    ST_OUT
  } state_t;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/circular_wind_direction_filter.sv
// circular wind direction filter
// input channel: in_valid / in_stall carry vane angle and boat heading,
// both in 1/16 degree. result channel: out_valid / out_stall carry one
// wind direction (0..5759) per input transfer, in order.
// configuration: apb-style port, registers at byte addresses 0, 4, 8, 12
// (vane offset, filter gain, manual mode, manual direction); the user must
// write them only while the block is idle; the block itself does not enforce this.
// one item at a time: in_stall is high from the input transfer until the
// result is loaded into the output register. a filtered item passes
// through the angle wrap, the bit-serial conversion of the angle to a
// binary phase, the rotation, rounding, the smoothing multiplies, the
// vectoring (skipped for a zero smoothed vector) and output. in manual
// mode an item goes straight to the output state.
// the next item is taken while a result still waits in the output register.
// if the receiver stalls, the result holds and the block waits with its
// next result until the output register frees up.
// reset (rst_n low, synchronous) restores register defaults and the
// filter state (cosine one, sine zero).
module circular_wind_direction_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] in_vane_angle,
  input  logic [12:0] in_boat_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_wind_direction,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cwdf_pkg::*;

  state_t state_r, state_nxt;

  logic [12:0] vane_offset_r;
  logic [15:0] filter_gain_r;
  logic        manual_mode_r;
  logic [12:0] manual_direction_r;

  logic signed [15:0] smooth_cos_r;
  logic signed [15:0] smooth_sin_r;

  logic [14:0]        raw_r;
  logic [44:0]        dvd_r;
  logic [12:0]        rem_r;
  logic [31:0]        quo_r;
  logic [5:0]         div_cnt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [33:0] z_r;
  logic [31:0]        vz_r;
  logic               flip_r;
  logic signed [15:0] c_r;
  logic signed [15:0] s_r;
  logic signed [33:0] prod_r;
  logic [12:0]        result_r;
  logic               out_valid_r, out_valid_nxt;
  logic [12:0]        out_dir_r;

  logic cfg_wr;
  logic in_xfer;
  logic out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_xfer = in_valid && !in_stall;

  // register read
  always_comb begin
    prdata = 32'd0;
    case (paddr[3:2])
      2'd0: prdata = {19'd0, vane_offset_r};
      2'd1: prdata = {16'd0, filter_gain_r};
      2'd2: prdata = {31'd0, manual_mode_r};
      2'd3: prdata = {19'd0, manual_direction_r};
      default: prdata = 32'd0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vane_offset_r      <= 13'd512;
      filter_gain_r      <= 16'd923;
      manual_mode_r      <= 1'b0;
      manual_direction_r <= 13'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        2'd0: vane_offset_r      <= pwdata[12:0];
        2'd1: filter_gain_r      <= pwdata[15:0];
        2'd2: manual_mode_r      <= pwdata[0];
        2'd3: manual_direction_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // rounding of a q4.30 value to q2.14 with saturation
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = {v[33], v} + 35'sd32768;
    r = 19'(t >>> 16);
    if (r > 19'sd16384)       return 16'sd16384;
    else if (r < -19'sd16384) return -16'sd16384;
    else                      return r[15:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = manual_mode_r ? ST_OUT : ST_MODR;
      ST_MODR:  if (raw_r < 15'(TURN_UNITS)) state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == 6'd44) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_ROT;
      ST_ROT:   if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_SMC;
      ST_SMC:   state_nxt = ST_SMS;
      ST_SMS:   state_nxt = ST_SMU;
      ST_SMU:   state_nxt = ST_VINIT;
      ST_VINIT: state_nxt = (smooth_cos_r == 16'sd0 && smooth_sin_r == 16'sd0) ?
                            ST_OUT : ST_VEC;
      ST_VEC:   if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // shared smoothing multiplier
  logic signed [16:0] mul_a;
  logic signed [33:0] mul_p;
  logic signed [17:0] delta;
  always_comb begin
    mul_a = (state_r == ST_SMC) ? (17'(c_r) - 17'(smooth_cos_r))
                                : (17'(s_r) - 17'(smooth_sin_r));
    mul_p = 34'(mul_a) * 34'($signed({1'b0, filter_gain_r}));
    delta = 18'((prod_r + 34'sd32768) >>> 16);
  end

  // cordic shifts
  logic signed [33:0] dx, dy;
  logic [31:0]        atan_v;
  always_comb begin
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    atan_v = atan_turn(5'(cnt_r));
  end

  // division step, phase to units
  logic [13:0] div_t;
  logic [37:0] p45;
  logic [38:0] units_w;
  logic [12:0] units;
  always_comb begin
    div_t   = {rem_r, dvd_r[44]};
    p45     = {1'b0, vz_r, 5'd0} + {3'd0, vz_r, 3'd0} + {4'd0, vz_r, 2'd0}
              + {6'd0, vz_r};
    units_w = ({1'b0, p45} + 39'd16777216) >> 25;
    units   = (units_w[12:0] >= 13'(TURN_UNITS)) ? 13'd0 : units_w[12:0];
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_cos_r <= 16'sd16384;
      smooth_sin_r <= 16'sd0;
    end else if (state_r == ST_SMS) begin
      smooth_cos_r <= 16'(18'(smooth_cos_r) + delta);
    end else if (state_r == ST_SMU) begin
      smooth_sin_r <= 16'(18'(smooth_sin_r) + delta);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        raw_r    <= 15'(vane_offset_r) + 15'd11520 + 15'(in_boat_heading)
                    - 15'(in_vane_angle);
        result_r <= (manual_direction_r >= 13'(TURN_UNITS)) ?
                    manual_direction_r - 13'(TURN_UNITS) : manual_direction_r;
      end
      ST_MODR: begin
        if (raw_r >= 15'(TURN_UNITS)) raw_r <= raw_r - 15'(TURN_UNITS);
        dvd_r     <= {raw_r[12:0], 32'd2880};
        rem_r     <= 13'd0;
        div_cnt_r <= 6'd0;
      end
      ST_DIV: begin
        if (div_t >= 14'(TURN_UNITS)) begin
          rem_r <= 13'(div_t - 14'(TURN_UNITS));
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= div_t[12:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        dvd_r     <= {dvd_r[43:0], 1'b0};
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      ST_PREP: begin
        x_r   <= 34'sh026DD3B6A;
        y_r   <= 34'sd0;
        cnt_r <= '0;
        if ($signed({{2{quo_r[31]}}, quo_r}) > 34'sh040000000) begin
          z_r    <= $signed({{2{quo_r[31]}}, quo_r}) - 34'sh080000000;
          flip_r <= 1'b1;
        end else if ($signed({{2{quo_r[31]}}, quo_r}) < -34'sh040000000) begin
          z_r    <= $signed({{2{quo_r[31]}}, quo_r}) + 34'sh080000000;
          flip_r <= 1'b1;
        end else begin
          z_r    <= $signed({{2{quo_r[31]}}, quo_r});
          flip_r <= 1'b0;
        end
      end
      ST_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - $signed({2'b00, atan_v});
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + $signed({2'b00, atan_v});
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_ROUND: begin
        c_r <= flip_r ? -to_q14(x_r) : to_q14(x_r);
        s_r <= flip_r ? -to_q14(y_r) : to_q14(y_r);
      end
      ST_SMC: prod_r <= mul_p;
      ST_SMS: prod_r <= mul_p;
      ST_SMU: ;
      ST_VINIT: begin
        cnt_r    <= '0;
        result_r <= 13'd0;
        if (smooth_cos_r < 16'sd0) begin
          x_r  <= -$signed({{2{smooth_cos_r[15]}}, smooth_cos_r, 16'd0});
          y_r  <= -$signed({{2{smooth_sin_r[15]}}, smooth_sin_r, 16'd0});
          vz_r <= 32'h80000000;
        end else begin
          x_r  <= $signed({{2{smooth_cos_r[15]}}, smooth_cos_r, 16'd0});
          y_r  <= $signed({{2{smooth_sin_r[15]}}, smooth_sin_r, 16'd0});
          vz_r <= 32'd0;
        end
      end
      ST_VEC: begin
        if (!y_r[33]) begin
          x_r  <= x_r + dx;
          y_r  <= y_r - dy;
          vz_r <= vz_r + atan_v;
        end else begin
          x_r  <= x_r - dx;
          y_r  <= y_r + dy;
          vz_r <= vz_r - atan_v;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_CONV: result_r <= units;
      ST_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_dir_r <= result_r;
  end

  assign out_valid          = out_valid_r;
  assign out_wind_direction = out_dir_r;

  // checks
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_wind_direction < 13'(TURN_UNITS))
    else $error("wind direction out of range");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while an item is in progress");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    smooth_cos_r <= 16'sd16384 && smooth_cos_r >= -16'sd16384)
    else $error("smoothed cosine out of range");

  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    smooth_sin_r <= 16'sd16384 && smooth_sin_r >= -16'sd16384)
    else $error("smoothed sine out of range");

endmodule

>>> bench/circular_wind_direction_filter_tb.sv
`timescale 1ns / 1ps

module circular_wind_direction_filter_tb;
  import cwdf_pkg::*;

  localparam int  ATAN_LEN    = 24;
  localparam int  LONG_HOLD   = 2500;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  SETTLE      = 120;
  localparam longint Q30_INV_GAIN = 64'h26DD3B6A;
  localparam int  Q14_ONE     = 16384;

  localparam logic [31:0] ATAN_STEP [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [12:0] in_vane_angle = '0;
  logic [12:0] in_boat_heading = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_wind_direction;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  circular_wind_direction_filter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vane_angle(in_vane_angle), .in_boat_heading(in_boat_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_wind_direction(out_wind_direction),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  logic [12:0] mdl_offset;
  logic [15:0] mdl_gain;
  logic        mdl_manual;
  logic [12:0] mdl_manual_dir;
  int          mdl_cos;
  int          mdl_sin;

  logic [12:0] wind_dir_expected [$];
  int          error_count = 0;
  int          samples_sent = 0;
  int          directions_checked = 0;
  int          manual_samples = 0;
  int          cycle_count = 0;

  // receiver stall control
  int          stall_mode = 0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  function automatic logic [31:0] units_to_phase(input logic [12:0] u);
    logic [63:0] t;
    t = (({51'd0, u}) << 32) + 64'd2880;
    t = t / 64'd5760;
    return t[31:0];
  endfunction

  function automatic logic [12:0] phase_to_units(input logic [31:0] p);
    logic [63:0] t;
    t = ({32'd0, p} * 64'd5760 + 64'h80000000) >> 32;
    if (t >= 64'd5760) t = 0;
    return t[12:0];
  endfunction

  function automatic int round_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    return int'(r);
  endfunction

  // rotation cordic: unit vector of a binary phase
  task automatic phase_to_unit_vector(input logic [31:0] ph, output int c, output int s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'({32'd0, ph});
    x = Q30_INV_GAIN;
    y = 0;
    flip = 1'b0;
    if (z >= 64'sh80000000) z = z - 64'sh100000000;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'({32'd0, ATAN_STEP[i]});
      end else begin
        x = x + dx; y = y - dy; z = z + longint'({32'd0, ATAN_STEP[i]});
      end
    end
    c = round_q14(x);
    s = round_q14(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  // vectoring cordic: binary phase of a (cos, sin) pair
  function automatic logic [31:0] vector_phase(input int c, input int s);
    longint      x, y, dx, dy;
    logic [31:0] z;
    x = longint'(c) * 65536;
    y = longint'(s) * 65536;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic int lowpass(input int state, input int target, input logic [15:0] g);
    longint prod;
    prod = longint'(target - state) * longint'({16'd0, g});
    return state + int'((prod + 32768) >>> 16);
  endfunction

  // expected wind direction for one sample, updating the filter state
  task automatic predict_wind_direction(input logic [12:0] vane, input logic [12:0] head);
    logic [31:0] raw;
    logic [12:0] dir;
    int          c, s;
    if (mdl_manual) begin
      dir = (mdl_manual_dir >= 13'd5760) ? mdl_manual_dir - 13'd5760 : mdl_manual_dir;
      manual_samples++;
    end else begin
      raw = (32'(mdl_offset) + 32'd11520 + 32'(head) - 32'(vane)) % 32'd5760;
      phase_to_unit_vector(units_to_phase(raw[12:0]), c, s);
      mdl_cos = lowpass(mdl_cos, c, mdl_gain);
      mdl_sin = lowpass(mdl_sin, s, mdl_gain);
      if (mdl_cos == 0 && mdl_sin == 0) dir = '0;
      else dir = phase_to_units(vector_phase(mdl_cos, mdl_sin));
    end
    wind_dir_expected.push_back(dir);
  endtask

  // one register write: setup then access phase, then back to idle
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_VANE_OFFSET: mdl_offset = data[12:0];
      ADDR_FILTER_GAIN: mdl_gain = data[15:0];
      ADDR_MANUAL_MODE: mdl_manual = data[0];
      ADDR_MANUAL_DIR:  mdl_manual_dir = data[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [12:0] off, input logic [15:0] g,
                            input logic man, input logic [12:0] mdir);
    reg_write(ADDR_VANE_OFFSET, {19'd0, off});
    reg_write(ADDR_FILTER_GAIN, {16'd0, g});
    reg_write(ADDR_MANUAL_MODE, {31'd0, man});
    reg_write(ADDR_MANUAL_DIR, {19'd0, mdir});
  endtask

  // offer one sample and hold it until the transfer
  task automatic send_sample(input logic [12:0] vane, input logic [12:0] head);
    in_valid <= 1'b1;
    in_vane_angle <= vane;
    in_boat_heading <= head;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_wind_direction(vane, head);
    samples_sent++;
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for all results, then let the block settle before touching registers
  task automatic drain();
    idle_cycles(1);
    while (wind_dir_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (wind_dir_expected.size() == 0) begin
        $display("%0t: unexpected wind_direction transfer, actual %0d",
                 $time, out_wind_direction);
        error_count++;
      end else begin
        if (out_wind_direction !== wind_dir_expected[0]) begin
          $display("%0t: wind_direction mismatch, expected %0d, actual %0d",
                   $time, wind_dir_expected[0], out_wind_direction);
          error_count++;
        end
        void'(wind_dir_expected.pop_front());
        directions_checked++;
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // defaults after reset
  task automatic test_reset_defaults();
    send_sample(13'd0, 13'd0);
    send_sample(13'd512, 13'd0);
    send_sample(13'd100, 13'd4000);
    drain();
  endtask

  // field and register extremes, fast and slow filter
  task automatic test_extremes();
    set_config(13'd0, 16'd65535, 1'b0, 13'd0);
    send_sample(13'd0, 13'd0);
    send_sample(13'd5759, 13'd0);
    send_sample(13'd0, 13'd5759);
    send_sample(13'd5759, 13'd5759);
    send_sample(13'd8191, 13'd0);
    send_sample(13'd0, 13'd8191);
    drain();
    set_config(13'd8191, 16'd1, 1'b0, 13'd0);
    send_sample(13'd8191, 13'd8191);
    send_sample(13'd1440, 13'd2880);
    drain();
    set_config(13'd5759, 16'd65535, 1'b0, 13'd0);
    send_sample(13'd0, 13'd4320);
    send_sample(13'd2880, 13'd1);
    drain();
  endtask

  // zero gain holds the state
  task automatic test_zero_gain();
    set_config(13'd0, 16'd0, 1'b0, 13'd0);
    send_sample(13'd0, 13'd2880);
    send_sample(13'd1234, 13'd77);
    drain();
  endtask

  // drive the smoothed vector toward the origin
  task automatic test_zero_vector();
    set_config(13'd0, 16'd65535, 1'b0, 13'd0);
    repeat (3) send_sample(13'd0, 13'd0);
    drain();
    reg_write(ADDR_FILTER_GAIN, 32'd32768);
    send_sample(13'd0, 13'd2880);
    drain();
  endtask

  // manual output, including values above one turn
  task automatic test_manual();
    set_config(13'd0, 16'd923, 1'b1, 13'd0);
    send_sample(13'd10, 13'd20);
    drain();
    reg_write(ADDR_MANUAL_DIR, 32'd5759);
    send_sample(13'd8191, 13'd8191);
    drain();
    reg_write(ADDR_MANUAL_DIR, 32'd5760);
    send_sample(13'd0, 13'd0);
    drain();
    reg_write(ADDR_MANUAL_DIR, 32'd8191);
    send_sample(13'd0, 13'd0);
    drain();
    reg_write(ADDR_MANUAL_MODE, 32'd0);
    send_sample(13'd300, 13'd600);
    drain();
  endtask

  function automatic logic [12:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 13'($urandom_range(5760, 8191));
    return 13'($urandom_range(0, 5759));
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 1));
      1: return 16'd65535;
      2: return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random samples over several register settings, bursts and stalls
  task automatic test_random(input int total);
    int sent;
    int burst;
    int phase_len;
    int phase_idx;
    sent = 0;
    phase_idx = 0;
    while (sent < total) begin
      set_config(rand_angle(), rand_gain(), ($urandom_range(0, 5) == 0), rand_angle());
      stall_mode = phase_idx % 3;
      phase_len = $urandom_range(60, 200);
      if (phase_idx == 2) hold_asks++;
      while (phase_len > 0 && sent < total) begin
        burst = $urandom_range(1, 20);
        while (burst > 0 && phase_len > 0 && sent < total) begin
          send_sample(rand_angle(), rand_angle());
          burst--;
          phase_len--;
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 150));
      end
      drain();
      phase_idx++;
    end
    stall_mode = 0;
  endtask

  initial begin
    mdl_offset = 13'd512;
    mdl_gain = 16'd923;
    mdl_manual = 1'b0;
    mdl_manual_dir = '0;
    mdl_cos = Q14_ONE;
    mdl_sin = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_zero_gain();
    test_zero_vector();
    test_manual();
    test_random(1350);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d samples (%0d in manual mode), %0d directions checked,",
             samples_sent, manual_samples, directions_checked);
    $display("register extremes, zero gain, zero vector, bursts, stalls and a long hold");
    if (error_count == 0 && wind_dir_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
